// ----- sv/wrst_pkg.sv -----
// Package for the weak reference slot table: table sizes, field widths,
// operation and status codes, FSM state and controller/datapath structs.
// No dependencies.
package wrst_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 2048;
    localparam int COUNT_BITS  = 16;
    localparam int HANDLE_BITS = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int TOP_W       = IDX_W + 1;

    // Fixed port field widths
    localparam int KIND_W   = 3;
    localparam int HANDLE_W = 16;
    localparam int SLOT_W   = 11;
    localparam int STATUS_W = 3;

    // Common width for slot versus high-water compares
    localparam int CMP_W = (SLOT_W > TOP_W) ? SLOT_W : TOP_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOP_W-1:0]      TOP_FULL  = TOP_W'(TABLE_DEPTH);

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_REF_OBJ   = 3'd0,
        KIND_REF_SLOT  = 3'd1,
        KIND_UNREF     = 3'd2,
        KIND_DEREF     = 3'd3,
        KIND_DESTROY   = 3'd4,
        KIND_CLEAR     = 3'd5
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_OVER  = 3'd2,
        ST_UNDER = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    // One slot memory word
    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic                   alive;
        logic [HANDLE_BITS-1:0] handle;
    } t_slot_word;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/wrst_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module wrst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/wrst_ctrl.sv -----
// Controller for the weak reference slot table: two-state sequencer that
// captures a transaction, then commits it once the result register is free.
// Depends on wrst_pkg.
module wrst_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wrst_pkg::t_dp_status i_status,
    output wrst_pkg::t_ctrl_cmd  o_cmd
);

    wrst_pkg::t_state r_state;
    wrst_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            wrst_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = wrst_pkg::S_EXEC;
                end
            end
            wrst_pkg::S_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = wrst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wrst_pkg::S_IDLE;
            end
        endcase
    end

    // A captured transaction is always followed by an execute cycle
    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == wrst_pkg::S_EXEC)
        else $error("capture not followed by execute");

    // Commit only in execute, never together with capture
    a_commit_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (r_state == wrst_pkg::S_EXEC && !o_cmd.capture))
        else $error("commit outside execute");

endmodule

// ----- sv/wrst_dp.sv -----
// Datapath for the weak reference slot table: slot memory, free stack memory,
// free_top and high_water registers, operation logic and result register.
// Depends on wrst_pkg and wrst_ram.
module wrst_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wrst_pkg::t_ctrl_cmd              i_cmd,
    output wrst_pkg::t_dp_status             o_status,
    input  logic [wrst_pkg::KIND_W-1:0]      i_kind,
    input  logic [wrst_pkg::HANDLE_W-1:0]    i_object_handle,
    input  logic [wrst_pkg::SLOT_W-1:0]      i_slot_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [wrst_pkg::SLOT_W-1:0]      o_result_slot,
    output logic [wrst_pkg::HANDLE_W-1:0]    o_result_handle,
    output logic                             o_object_present,
    output logic                             o_slot_freed,
    output logic [wrst_pkg::STATUS_W-1:0]    o_status_code
);

    localparam int WORD_W = $bits(wrst_pkg::t_slot_word);

    // Captured transaction
    logic [wrst_pkg::KIND_W-1:0]   r_kind;
    logic [wrst_pkg::HANDLE_W-1:0] r_handle;
    logic [wrst_pkg::SLOT_W-1:0]   r_slot;

    // Allocation state
    logic [wrst_pkg::TOP_W-1:0] r_free_top, n_free_top;
    logic [wrst_pkg::TOP_W-1:0] r_high_water, n_high_water;

    // Result register
    logic                          r_out_valid;
    logic [wrst_pkg::SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic [wrst_pkg::HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic                          r_res_present, n_res_present;
    logic                          r_res_freed, n_res_freed;
    wrst_pkg::t_status             r_res_status, n_res_status;

    // Memory ports
    logic                         sw_we, fs_we;
    logic [wrst_pkg::IDX_W-1:0]   sw_waddr, fs_waddr, sw_raddr, fs_raddr;
    logic [WORD_W-1:0]            sw_wdata_bits, sw_rdata_bits;
    logic [wrst_pkg::IDX_W-1:0]   fs_wdata, fs_rdata;
    wrst_pkg::t_slot_word         sw_rdata, sw_wdata;

    // Decode helpers
    logic                           slot_nz, slot_ok, push_req, wr_req;
    logic [wrst_pkg::IDX_W-1:0]     slot_idx, alloc_idx;
    logic [wrst_pkg::HANDLE_BITS-1:0] hnd;

    // Reads issue at capture; the slot address comes from the input port
    assign sw_raddr = wrst_pkg::IDX_W'(i_slot_index);
    assign fs_raddr = wrst_pkg::IDX_W'(r_free_top - 1'b1);

    wrst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (wrst_pkg::TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sw_we),
        .i_waddr (sw_waddr),
        .i_wdata (sw_wdata_bits),
        .i_re    (i_cmd.capture),
        .i_raddr (sw_raddr),
        .o_rdata (sw_rdata_bits)
    );

    wrst_ram #(
        .WIDTH (wrst_pkg::IDX_W),
        .DEPTH (wrst_pkg::TABLE_DEPTH)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    assign sw_rdata      = wrst_pkg::t_slot_word'(sw_rdata_bits);
    assign sw_wdata_bits = WORD_W'(sw_wdata);

    assign slot_idx = wrst_pkg::IDX_W'(r_slot);
    assign slot_nz  = (r_slot != '0);
    assign slot_ok  = wrst_pkg::CMP_W'(r_slot) < wrst_pkg::CMP_W'(r_high_water);
    assign hnd      = wrst_pkg::HANDLE_BITS'(r_handle);

    // Operation logic, evaluated on the captured transaction and read data
    always_comb begin
        n_res_slot    = r_slot;
        n_res_handle  = '0;
        n_res_present = 1'b0;
        n_res_freed   = 1'b0;
        n_res_status  = wrst_pkg::ST_OK;
        n_free_top    = r_free_top;
        n_high_water  = r_high_water;
        wr_req        = 1'b0;
        push_req      = 1'b0;
        alloc_idx     = '0;
        sw_waddr      = slot_idx;
        sw_wdata      = sw_rdata;
        fs_waddr      = wrst_pkg::IDX_W'(r_free_top);
        fs_wdata      = slot_idx;

        unique case (r_kind)
            wrst_pkg::KIND_REF_OBJ,
            wrst_pkg::KIND_REF_SLOT: begin
                if (r_kind == wrst_pkg::KIND_REF_OBJ && hnd == '0) begin
                    n_res_slot = '0;
                end else if (slot_nz) begin
                    // Increment an existing slot
                    if (!slot_ok) begin
                        n_res_status = wrst_pkg::ST_RANGE;
                    end else if (sw_rdata.count == wrst_pkg::COUNT_MAX) begin
                        n_res_status = wrst_pkg::ST_OVER;
                    end else begin
                        sw_wdata.count = sw_rdata.count + 1'b1;
                        wr_req         = 1'b1;
                    end
                end else if (r_kind == wrst_pkg::KIND_REF_OBJ) begin
                    // Allocate: pop the free stack, else grow high water
                    if (r_free_top != '0) begin
                        alloc_idx  = fs_rdata;
                        n_free_top = r_free_top - 1'b1;
                        wr_req     = 1'b1;
                    end else if (r_high_water != wrst_pkg::TOP_FULL) begin
                        alloc_idx    = wrst_pkg::IDX_W'(r_high_water);
                        n_high_water = r_high_water + 1'b1;
                        wr_req       = 1'b1;
                    end else begin
                        n_res_status = wrst_pkg::ST_FULL;
                    end
                    sw_waddr        = alloc_idx;
                    sw_wdata.count  = wrst_pkg::COUNT_BITS'(1);
                    sw_wdata.alive  = 1'b1;
                    sw_wdata.handle = hnd;
                    n_res_slot      = wrst_pkg::SLOT_W'(alloc_idx);
                end
            end
            wrst_pkg::KIND_UNREF: begin
                if (slot_nz) begin
                    if (!slot_ok) begin
                        n_res_status = wrst_pkg::ST_RANGE;
                    end else if (sw_rdata.count == '0) begin
                        n_res_status = wrst_pkg::ST_UNDER;
                    end else begin
                        sw_wdata.count = sw_rdata.count - 1'b1;
                        wr_req         = 1'b1;
                        push_req = (sw_rdata.count == wrst_pkg::COUNT_BITS'(1)) &&
                                   !sw_rdata.alive;
                    end
                end
            end
            wrst_pkg::KIND_DEREF: begin
                if (slot_nz) begin
                    if (!slot_ok) begin
                        n_res_status = wrst_pkg::ST_RANGE;
                    end else if (sw_rdata.alive) begin
                        n_res_handle  = wrst_pkg::HANDLE_W'(sw_rdata.handle);
                        n_res_present = 1'b1;
                    end
                end
            end
            wrst_pkg::KIND_DESTROY: begin
                if (slot_nz) begin
                    if (!slot_ok) begin
                        n_res_status = wrst_pkg::ST_RANGE;
                    end else if (sw_rdata.alive) begin
                        sw_wdata.alive = 1'b0;
                        wr_req         = 1'b1;
                        push_req       = (sw_rdata.count == '0);
                    end
                end
            end
            wrst_pkg::KIND_CLEAR: begin
                n_free_top   = '0;
                n_high_water = wrst_pkg::TOP_W'(1);
            end
            default: begin
            end
        endcase

        // Push a dead slot unless the stack is already full
        if (push_req && r_free_top != wrst_pkg::TOP_FULL) begin
            n_free_top  = r_free_top + 1'b1;
            n_res_freed = 1'b1;
        end
    end

    assign sw_we = i_cmd.commit && wr_req;
    assign fs_we = i_cmd.commit && n_res_freed;

    // Capture the transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_handle <= i_object_handle;
            r_slot   <= i_slot_index;
        end
    end

    // Allocation state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_top   <= '0;
            r_high_water <= wrst_pkg::TOP_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_free_top   <= n_free_top;
                r_high_water <= n_high_water;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_slot    <= n_res_slot;
            r_res_handle  <= n_res_handle;
            r_res_present <= n_res_present;
            r_res_freed   <= n_res_freed;
            r_res_status  <= n_res_status;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_result_slot     = r_res_slot;
    assign o_result_handle   = r_res_handle;
    assign o_object_present  = r_res_present;
    assign o_slot_freed      = r_res_freed;
    assign o_status_code     = r_res_status;

    // High water stays between the reserved slot and the table size
    a_high_water_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_water != '0 && r_high_water <= wrst_pkg::TOP_FULL)
        else $error("high water out of range");

    // The free stack never holds more than the table
    a_free_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_top <= wrst_pkg::TOP_FULL)
        else $error("free stack overrun");

    // A committed transaction always presents a result
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit without result");

endmodule

// ----- sv/weak_reference_slot_table_core.sv -----
// Weak reference slot table: reference counted handle table with free stack.
// Flow: a transaction is accepted with the slot and free stack reads issued,
//   then committed with the write-back and the result registered once the
//   result register is free; no new transaction is accepted until the commit.
// Reset: free stack empty, high water at 1, no result pending; slot and stack
//   memories are not cleared.
module weak_reference_slot_table_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [wrst_pkg::KIND_W-1:0]   i_kind,
    input  logic [wrst_pkg::HANDLE_W-1:0] i_object_handle,
    input  logic [wrst_pkg::SLOT_W-1:0]   i_slot_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wrst_pkg::SLOT_W-1:0]   o_result_slot,
    output logic [wrst_pkg::HANDLE_W-1:0] o_result_handle,
    output logic                          o_object_present,
    output logic                          o_slot_freed,
    output logic [wrst_pkg::STATUS_W-1:0] o_status
);

    wrst_pkg::t_ctrl_cmd  cmd;
    wrst_pkg::t_dp_status dp_status;

    // Sequencer
    wrst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    // Table datapath
    wrst_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (dp_status),
        .i_kind           (i_kind),
        .i_object_handle  (i_object_handle),
        .i_slot_index     (i_slot_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_slot    (o_result_slot),
        .o_result_handle  (o_result_handle),
        .o_object_present (o_object_present),
        .o_slot_freed     (o_slot_freed),
        .o_status_code    (o_status)
    );

endmodule
